// ===== hw/rtl/graph_vertex_degree_counter_core_assert.svh =====
// Assertion macros for the degree counter RTL.
`ifndef GRAPH_VERTEX_DEGREE_COUNTER_CORE_ASSERT_SVH
`define GRAPH_VERTEX_DEGREE_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GVDC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GVDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gvdc_pkg.sv =====
// Package: constants, codes and shared types of the degree counter.
`default_nettype none
package gvdc_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned DEGREE_BITS_DEF  = 32;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned VTX_W       = 10;
  localparam int unsigned OFF_W       = 32;
  localparam int unsigned DIR_W       = 2;
  localparam int unsigned VCNT_W      = 11;
  localparam int unsigned IDX_W       = 17;
  localparam int unsigned DEG_OUT_W   = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 48;

  // Item operation codes
  localparam logic [OP_W-1:0] OP_ENTRY  = 2'd0;
  localparam logic [OP_W-1:0] OP_OFFSET = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_OUT  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_IN   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_BOTH = 2'd2;

  // Layout codes
  localparam logic LAYOUT_EDGE = 1'b0;
  localparam logic LAYOUT_CSR  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT    = 2'd2;

  localparam logic [VCNT_W-1:0] VCOUNT_RESET  = 11'd1024;
  localparam logic [VCNT_W-1:0] ROWS_SEEN_MAX = 11'd2047;

  // Command from the sequencer to the degree memory
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/gvdc_store.sv =====
// Degree memory: one write port, one registered read port, clearing sweep after reset.
`default_nettype none
module gvdc_store import gvdc_pkg::*; #(
  parameter int unsigned DEPTH = MAX_VERTICES_DEF,
  parameter int unsigned DW    = DEGREE_BITS_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mem_cmd_t      cmd,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata,
  output logic               clr_busy
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  logic          we;
  logic [AW-1:0] wa;
  logic [DW-1:0] wd;

  // Sweep every entry to zero once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    we = clr_busy_r | cmd.wr;
    wa = clr_busy_r ? clr_addr_r : waddr;
    wd = clr_busy_r ? '0 : wdata;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata    = rdata_r;
  assign clr_busy = clr_busy_r;

endmodule
`default_nettype wire

// ===== hw/rtl/gvdc_ctrl.sv =====
// Item sequencer: decodes items, runs read-modify-write on the degree memory, holds the result.
`default_nettype none
module gvdc_ctrl import gvdc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned DEGREE_BITS  = DEGREE_BITS_DEF,
  localparam int unsigned AW          = $clog2(MAX_VERTICES)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // item side
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [OP_W-1:0]        in_op,
  input  wire logic [VTX_W-1:0]       in_first,
  input  wire logic [VTX_W-1:0]       in_second,
  input  wire logic [OFF_W-1:0]       in_offset,
  // configuration
  input  wire logic [DIR_W-1:0]       direction,
  input  wire logic                   layout,
  input  wire logic [VCNT_W-1:0]      vertex_count,
  // memory side
  input  wire logic                   clr_busy,
  output mem_cmd_t                    mem_cmd,
  output logic      [AW-1:0]          mem_waddr,
  output logic      [DEGREE_BITS-1:0] mem_wdata,
  output logic      [AW-1:0]          mem_raddr,
  input  wire logic [DEGREE_BITS-1:0] mem_rdata,
  // result side
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [VTX_W-1:0]       out_vertex,
  output logic      [DEG_OUT_W-1:0]   out_degree
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_MODIFY = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  typedef struct packed {
    logic bump_a;
    logic bump_b;
    logic row_wr;
    logic rd_req;
    logic rd_use;
  } job_t;

  state_t                 state_r, state_nxt;
  job_t                   job_r, job_nxt, job_dec;
  logic [AW-1:0]          addr_a_r, addr_a_nxt;
  logic [AW-1:0]          addr_b_r, addr_b_nxt;
  logic [VTX_W-1:0]       vtx_r, vtx_nxt;
  logic [OFF_W-1:0]       diff_r, diff_nxt;
  logic                   cur_b_r, cur_b_nxt;
  logic [OFF_W-1:0]       prev_off_r, prev_off_nxt;
  logic [VCNT_W-1:0]      rows_seen_r, rows_seen_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VTX_W-1:0]       out_vertex_r, out_vertex_nxt;
  logic [DEG_OUT_W-1:0]   out_degree_r, out_degree_nxt;

  logic                   accept;
  logic                   want_out, want_in;
  logic [IDX_W-1:0]       a_ext, b_ext, row_ext;
  logic                   a_use, b_use, row_use;
  logic [OFF_W:0]         off_sub;
  logic [63:0]            diff_wide;
  logic [DEGREE_BITS-1:0] row_deg;
  logic [DEGREE_BITS-1:0] inc_deg;

  function automatic logic in_use(input logic [IDX_W-1:0] v, input logic [VCNT_W-1:0] cnt);
    in_use = (v < IDX_W'(MAX_VERTICES)) && (v < IDX_W'(cnt));
  endfunction

  always_comb begin
    accept   = in_valid && in_ready;
    want_out = (direction != DIR_IN);
    want_in  = (direction != DIR_OUT);
    a_ext    = IDX_W'(in_first);
    b_ext    = IDX_W'(in_second);
    row_ext  = IDX_W'(rows_seen_r - VCNT_W'(1));
    a_use    = in_use(a_ext, vertex_count);
    b_use    = in_use(b_ext, vertex_count);
    row_use  = in_use(row_ext, vertex_count);
    // difference from the prior offset, zero when it would go negative
    off_sub  = {1'b0, in_offset} - {1'b0, prev_off_r};
    // clamp the row degree to the counter width
    diff_wide = 64'(diff_r);
    row_deg   = ((diff_wide >> DEGREE_BITS) != 64'd0) ? '1 : DEGREE_BITS'(diff_r);
    inc_deg   = (mem_rdata == '1) ? mem_rdata : mem_rdata + DEGREE_BITS'(1);
  end

  always_comb begin
    job_dec = '0;
    case (in_op)
      OP_ENTRY: begin
        if (layout == LAYOUT_EDGE) begin
          job_dec.bump_a = want_out && a_use;
          job_dec.bump_b = want_in && b_use;
        end else begin
          job_dec.bump_a = want_in && a_use;
        end
      end
      OP_OFFSET: begin
        job_dec.row_wr = (layout == LAYOUT_CSR) && (rows_seen_r != '0) && want_out && row_use;
      end
      OP_READ: begin
        job_dec.rd_req = 1'b1;
        job_dec.rd_use = a_use;
      end
      default: begin
        job_dec = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    addr_a_nxt     = addr_a_r;
    addr_b_nxt     = addr_b_r;
    vtx_nxt        = vtx_r;
    diff_nxt       = diff_r;
    cur_b_nxt      = cur_b_r;
    prev_off_nxt   = prev_off_r;
    rows_seen_nxt  = rows_seen_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_vertex_nxt = out_vertex_r;
    out_degree_nxt = out_degree_r;
    mem_cmd        = '0;
    mem_waddr      = cur_b_r ? addr_b_r : addr_a_r;
    mem_wdata      = inc_deg;
    mem_raddr      = addr_a_r;
    in_ready       = (state_r == ST_IDLE) && !clr_busy;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          job_nxt    = job_dec;
          addr_a_nxt = (in_op == OP_OFFSET) ? row_ext[AW-1:0] : a_ext[AW-1:0];
          addr_b_nxt = b_ext[AW-1:0];
          vtx_nxt    = in_first;
          diff_nxt   = off_sub[OFF_W] ? '0 : off_sub[OFF_W-1:0];
          if ((in_op == OP_OFFSET) && (layout == LAYOUT_CSR)) begin
            prev_off_nxt = in_offset;
            if (rows_seen_r != ROWS_SEEN_MAX) begin
              rows_seen_nxt = rows_seen_r + VCNT_W'(1);
            end
          end
          if (job_dec != '0) begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        if (job_r.row_wr) begin
          mem_cmd.wr = 1'b1;
          mem_waddr  = addr_a_r;
          mem_wdata  = row_deg;
          job_nxt    = '0;
          state_nxt  = ST_IDLE;
        end else if (job_r.bump_a) begin
          mem_cmd.rd = 1'b1;
          mem_raddr  = addr_a_r;
          cur_b_nxt  = 1'b0;
          state_nxt  = ST_MODIFY;
        end else if (job_r.bump_b) begin
          mem_cmd.rd = 1'b1;
          mem_raddr  = addr_b_r;
          cur_b_nxt  = 1'b1;
          state_nxt  = ST_MODIFY;
        end else if (job_r.rd_req) begin
          mem_cmd.rd = job_r.rd_use;
          mem_raddr  = addr_a_r;
          state_nxt  = ST_RESULT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MODIFY: begin
        // write back the incremented count; a second bump reads in the following cycle, from ISSUE
        mem_cmd.wr = 1'b1;
        if (cur_b_r) begin
          job_nxt.bump_b = 1'b0;
          state_nxt      = ST_IDLE;
        end else begin
          job_nxt.bump_a = 1'b0;
          state_nxt      = job_r.bump_b ? ST_ISSUE : ST_IDLE;
        end
      end
      ST_RESULT: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = vtx_r;
          out_degree_nxt = job_r.rd_use ? DEG_OUT_W'(mem_rdata) : '0;
          job_nxt        = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      job_r       <= '0;
      cur_b_r     <= 1'b0;
      prev_off_r  <= '0;
      rows_seen_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      cur_b_r     <= cur_b_nxt;
      prev_off_r  <= prev_off_nxt;
      rows_seen_r <= rows_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_a_r     <= addr_a_nxt;
    addr_b_r     <= addr_b_nxt;
    vtx_r        <= vtx_nxt;
    diff_r       <= diff_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_degree_r <= out_degree_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_vertex = out_vertex_r;
  assign out_degree = out_degree_r;

endmodule
`default_nettype wire

// ===== hw/rtl/graph_vertex_degree_counter_core.sv =====
// Top level of the vertex degree counter: ports, configuration registers, assertions.
//
// Keeps one saturating degree counter per vertex in a single memory of MAX_VERTICES
// entries and counts edge-list pairs or compressed-row offsets and column indices
// into it; a read item returns one vertex's degree on the out_ channel. Items are
// worked one at a time, and every counted vertex is a read followed by a write-back
// through the memory's single write port: an edge counted at both ends goes through
// ISSUE and MODIFY for each end, a row offset writes its degree from ISSUE, and a
// read waits in RESULT while the result register is still held by out_tready low.
// After reset a clearing pass over all MAX_VERTICES entries zeroes the memory with
// in_tready low; configuration writes are taken throughout, and cfg_ready is always
// high. Write configuration only while the block is idle.
`default_nettype none
`include "graph_vertex_degree_counter_core_assert.svh"
module graph_vertex_degree_counter_core import gvdc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned DEGREE_BITS  = DEGREE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [9:0] first_vertex, [19:10] second_vertex, [51:20] row_offset, [55:52] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] op
  input  wire logic [OP_W-1:0]        in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [9:0] read_vertex, [41:10] degree_value, [47:42] zero
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);

  logic [DIR_W-1:0]       direction_r;
  logic                   layout_r;
  logic [VCNT_W-1:0]      vcount_r;

  mem_cmd_t               mem_cmd;
  logic [AW-1:0]          mem_waddr;
  logic [AW-1:0]          mem_raddr;
  logic [DEGREE_BITS-1:0] mem_wdata;
  logic [DEGREE_BITS-1:0] mem_rdata;
  logic                   clr_busy;
  logic [VTX_W-1:0]       res_vertex;
  logic [DEG_OUT_W-1:0]   res_degree;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_BOTH;
      layout_r    <= LAYOUT_EDGE;
      vcount_r    <= VCOUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIRECTION: direction_r <= cfg_data[DIR_W-1:0];
        CFG_LAYOUT:    layout_r    <= cfg_data[0];
        CFG_VCOUNT:    vcount_r    <= cfg_data[VCNT_W-1:0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  gvdc_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .DEGREE_BITS  (DEGREE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_op        (in_tuser),
    .in_first     (in_tdata[9:0]),
    .in_second    (in_tdata[19:10]),
    .in_offset    (in_tdata[51:20]),
    .direction    (direction_r),
    .layout       (layout_r),
    .vertex_count (vcount_r),
    .clr_busy     (clr_busy),
    .mem_cmd      (mem_cmd),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_vertex   (res_vertex),
    .out_degree   (res_degree)
  );

  gvdc_store #(
    .DEPTH (MAX_VERTICES),
    .DW    (DEGREE_BITS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (mem_cmd),
    .waddr    (mem_waddr),
    .wdata    (mem_wdata),
    .raddr    (mem_raddr),
    .rdata    (mem_rdata),
    .clr_busy (clr_busy)
  );

  assign out_tdata = {6'd0, res_degree, res_vertex};

  `GVDC_ASSERT_SAME(a_idle_during_clear, clr_busy, (mem_cmd == '0) && !in_tready, "memory access or item accepted during clearing pass")
  `GVDC_ASSERT_SAME(a_cmd_exclusive, mem_cmd.wr, !mem_cmd.rd, "memory read and write issued together")
  `GVDC_ASSERT_NEXT(a_read_busy, in_tvalid && in_tready && (in_tuser == OP_READ), !in_tready, "read item did not occupy the sequencer")

endmodule
`default_nettype wire
